@@ rtl/core/segmented_table_interpolator_macros.svh @@
// Assertion macros used by the interpolator back end (sti_back).
`ifndef SEGMENTED_TABLE_INTERPOLATOR_MACROS_SVH
`define SEGMENTED_TABLE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STI_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("sti: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("sti: next-cycle check failed");

`endif

@@ rtl/core/sti_pkg.sv @@
`timescale 1ns / 1ps

package sti_pkg;

    localparam int SEG_POINTS  = 256;
    localparam int SEG_COUNT   = 3;
    localparam int ROW_LEN     = SEG_POINTS + 1;
    localparam int STORE_DEPTH = SEG_COUNT * ROW_LEN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(SEG_POINTS);
    localparam int FRAC_W      = 24;
    localparam int POS_IDX_W   = 24;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_W-1:0] HALF_Q24 = 32'h0080_0000;
    localparam logic [FRAC_W:0]   ONE_Q24  = 25'h100_0000;

    typedef enum logic [1:0] {
        KIND_WRITE      = 2'd0,
        KIND_DENSITY    = 2'd1,
        KIND_CUMULATIVE = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUND_ONE      = 3'd0,
        CFG_BOUND_TWO      = 3'd1,
        CFG_BOUND_THREE    = 3'd2,
        CFG_INV_STEP_ONE   = 3'd3,
        CFG_INV_STEP_TWO   = 3'd4,
        CFG_INV_STEP_THREE = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [30:0]       bound_one;
        logic [30:0]       bound_two;
        logic [30:0]       bound_three;
        logic [DATA_W-1:0] inv_step_one;
        logic [DATA_W-1:0] inv_step_two;
        logic [DATA_W-1:0] inv_step_three;
    } sti_cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic              pick;
        logic              wr_ok;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              neg;
        logic              zero;
        logic              tail;
        logic [1:0]        seg;
        logic [DATA_W-1:0] diff;
        logic [DATA_W-1:0] inv;
    } sti_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       neg;
        logic       zero;
        logic       tail;
    } sti_flags_t;

endpackage

@@ rtl/core/sti_in_if.sv @@
`timescale 1ns / 1ps

interface sti_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic               table_pick;
    logic [1:0]         segment;
    logic [8:0]         entry_index;
    logic [31:0]        entry_value;
    logic signed [31:0] energy;

    modport source (
        output valid, kind, table_pick, segment, entry_index, entry_value, energy,
        input  ready
    );
    modport sink (
        input  valid, kind, table_pick, segment, entry_index, entry_value, energy,
        output ready
    );
endinterface

@@ rtl/core/sti_out_if.sv @@
`timescale 1ns / 1ps

interface sti_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        in_tail;

    modport source (
        output valid, value, in_tail,
        input  ready
    );
    modport sink (
        input  valid, value, in_tail,
        output ready
    );
endinterface

@@ rtl/core/segmented_table_interpolator.sv @@
// Piecewise linear lookup over a density table and a cumulative table, each of
// three segments with 257 grid points. A write item (kind 0) stores one table
// entry when its segment and index are in range, and gives no result; a
// density or cumulative query gives one result. Results leave in order; one
// item is taken per cycle while the result side is ready. The pipeline has a
// single 32x32 position multiplier and uses the two read ports of each table
// memory. A four-entry queue sits between the classifying front end and the
// lookup pipeline, so either side may stall alone. Table memories are not
// cleared at reset: every entry a query reads must be written first. Write
// configuration registers only while no query is in flight.
`timescale 1ns / 1ps

module segmented_table_interpolator (
    input  logic                               clk,
    input  logic                               rst_n,
    sti_in_if.sink                             item,
    sti_out_if.source                          result,
    input  logic                               cfg_we,
    input  logic [sti_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sti_pkg::DATA_W-1:0]         cfg_data
);

    sti_pkg::sti_cfg_t  cfg_reg;
    sti_pkg::sti_item_t push_item;
    sti_pkg::sti_item_t head;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sti_pkg::CFG_BOUND_ONE:      cfg_reg.bound_one      <= cfg_data[30:0];
                sti_pkg::CFG_BOUND_TWO:      cfg_reg.bound_two      <= cfg_data[30:0];
                sti_pkg::CFG_BOUND_THREE:    cfg_reg.bound_three    <= cfg_data[30:0];
                sti_pkg::CFG_INV_STEP_ONE:   cfg_reg.inv_step_one   <= cfg_data;
                sti_pkg::CFG_INV_STEP_TWO:   cfg_reg.inv_step_two   <= cfg_data;
                sti_pkg::CFG_INV_STEP_THREE: cfg_reg.inv_step_three <= cfg_data;
                default:                     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    sti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg_reg),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    sti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    sti_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

@@ rtl/core/sti_ram.sv @@
`timescale 1ns / 1ps

module sti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ rtl/core/sti_queue.sv @@
`timescale 1ns / 1ps

module sti_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sti_pkg::sti_item_t  push_item,
    input  logic                pop,
    output sti_pkg::sti_item_t  head,
    output logic                full,
    output logic                empty
);

    sti_pkg::sti_item_t               slots_reg [sti_pkg::QUEUE_DEPTH];
    logic [sti_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sti_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sti_pkg::QCNT_W-1:0]       count_reg;

    function automatic logic [sti_pkg::QPTR_W-1:0] step_ptr(
        input logic [sti_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == sti_pkg::QPTR_W'(sti_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return ptr + sti_pkg::QPTR_W'(1);
    endfunction

    assign head  = slots_reg[rd_ptr_reg];
    assign full  = (count_reg == sti_pkg::QCNT_W'(sti_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= step_ptr(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= step_ptr(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + sti_pkg::QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - sti_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/sti_front.sv @@
`timescale 1ns / 1ps

module sti_front (
    input  logic                clk,
    input  logic                rst_n,
    sti_in_if.sink              item,
    input  sti_pkg::sti_cfg_t   cfg,
    input  logic                full,
    output logic                push,
    output sti_pkg::sti_item_t  push_item
);

    logic        f_valid_reg;
    logic [1:0]  f_kind_reg;
    logic        f_pick_reg;
    logic [1:0]  f_seg_reg;
    logic [8:0]  f_index_reg;
    logic [31:0] f_value_reg;
    logic        f_neg_reg;
    logic        f_zero_reg;
    logic [31:0] f_mag_reg;
    logic [31:0] mag_next;

    logic        accept;
    logic        lt1, lt2, lt3;
    logic [31:0] d1, d2;

    assign item.ready = !f_valid_reg || !full;
    assign accept     = item.valid && item.ready;
    assign push       = f_valid_reg && !full;
    assign mag_next   = item.energy[31] ? (~item.energy + 32'd1) : item.energy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            f_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_kind_reg  <= item.kind;
            f_pick_reg  <= item.table_pick;
            f_seg_reg   <= item.segment;
            f_index_reg <= item.entry_index;
            f_value_reg <= item.entry_value;
            f_neg_reg   <= item.energy[31];
            f_zero_reg  <= (item.energy == 32'sd0);
            f_mag_reg   <= mag_next;
        end
    end

    // pick the segment by strict compares, all differences formed in parallel
    assign lt1 = f_mag_reg < {1'b0, cfg.bound_one};
    assign lt2 = f_mag_reg < {1'b0, cfg.bound_two};
    assign lt3 = f_mag_reg < {1'b0, cfg.bound_three};
    assign d1  = f_mag_reg - {1'b0, cfg.bound_one};
    assign d2  = f_mag_reg - {1'b0, cfg.bound_two};

    always_comb
    begin
        push_item       = '0;
        push_item.kind  = f_kind_reg;
        push_item.pick  = f_pick_reg;
        push_item.wr_ok = (f_seg_reg < 2'(sti_pkg::SEG_COUNT))
                          && (32'(f_index_reg) <= 32'(sti_pkg::SEG_POINTS));
        push_item.waddr = sti_pkg::ADDR_W'(f_seg_reg) * sti_pkg::ADDR_W'(sti_pkg::ROW_LEN)
                          + sti_pkg::ADDR_W'(f_index_reg);
        push_item.wdata = f_value_reg;
        push_item.neg   = f_neg_reg;
        push_item.zero  = f_zero_reg;
        if (lt1)
        begin
            push_item.seg  = 2'd0;
            push_item.diff = f_mag_reg;
            push_item.inv  = cfg.inv_step_one;
        end
        else if (lt2)
        begin
            push_item.seg  = 2'd1;
            push_item.diff = d1;
            push_item.inv  = cfg.inv_step_two;
        end
        else if (lt3)
        begin
            push_item.seg  = 2'd2;
            push_item.diff = d2;
            push_item.inv  = cfg.inv_step_three;
        end
        else
        begin
            push_item.tail = 1'b1;
            push_item.seg  = 2'd2;
        end
    end

endmodule

@@ rtl/core/sti_back.sv @@
`timescale 1ns / 1ps
`include "segmented_table_interpolator_macros.svh"

module sti_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sti_pkg::sti_item_t  head,
    input  logic                empty,
    output logic                pop,
    sti_out_if.source           result
);

    logic adv;

    logic                       s1_valid_reg;
    sti_pkg::sti_item_t         s1_item_reg;
    logic [63:0]                s1_pos_reg;

    logic [sti_pkg::POS_IDX_W-1:0] idx_full;
    logic [sti_pkg::IDX_W-1:0]     idx;
    logic [sti_pkg::FRAC_W:0]      frac;
    logic [sti_pkg::ADDR_W-1:0]    addr_a;
    logic [sti_pkg::ADDR_W-1:0]    addr_b;
    logic                          s1_query;
    logic                          dens_we;
    logic                          cum_we;

    logic                       s2_valid_reg;
    sti_pkg::sti_flags_t        s2_flags_reg;
    logic [sti_pkg::FRAC_W:0]   s2_frac_reg;
    logic [31:0]                dens_qa, dens_qb, cum_qa, cum_qb;
    logic [31:0]                a_sel, b_sel;
    logic signed [32:0]         delta;
    logic signed [58:0]         prod_next;

    logic                       s3_valid_reg;
    sti_pkg::sti_flags_t        s3_flags_reg;
    logic [31:0]                s3_a_reg;
    logic signed [58:0]         s3_prod_reg;
    logic signed [58:0]         rounded;
    logic signed [34:0]         ival_wide;
    logic [31:0]                ival;
    logic [31:0]                integ;
    logic [32:0]                sum_pos;
    logic [31:0]                value_next;

    logic                       out_valid_reg;
    logic [31:0]                out_value_reg;
    logic                       out_tail_reg;

    assign adv = !out_valid_reg || result.ready;
    assign pop = adv && !empty;

    // grid position: clamp the index to the last interval
    assign idx_full = s1_pos_reg[63:40];

    always_comb
    begin
        if (idx_full >= sti_pkg::POS_IDX_W'(sti_pkg::SEG_POINTS))
        begin
            idx  = sti_pkg::IDX_W'(sti_pkg::SEG_POINTS - 1);
            frac = sti_pkg::ONE_Q24;
        end
        else
        begin
            idx  = idx_full[sti_pkg::IDX_W-1:0];
            frac = {1'b0, s1_pos_reg[39:16]};
        end
    end

    assign addr_a = sti_pkg::ADDR_W'(s1_item_reg.seg) * sti_pkg::ADDR_W'(sti_pkg::ROW_LEN)
                    + sti_pkg::ADDR_W'(idx);
    assign addr_b = addr_a + sti_pkg::ADDR_W'(1);

    assign s1_query = (s1_item_reg.kind == sti_pkg::KIND_DENSITY)
                      || (s1_item_reg.kind == sti_pkg::KIND_CUMULATIVE);
    assign dens_we  = adv && s1_valid_reg && (s1_item_reg.kind == sti_pkg::KIND_WRITE)
                      && s1_item_reg.wr_ok && !s1_item_reg.pick;
    assign cum_we   = adv && s1_valid_reg && (s1_item_reg.kind == sti_pkg::KIND_WRITE)
                      && s1_item_reg.wr_ok && s1_item_reg.pick;

    sti_ram #(
        .WIDTH (sti_pkg::DATA_W),
        .DEPTH (sti_pkg::STORE_DEPTH)
    ) u_density_ram (
        .clk     (clk),
        .we      (dens_we),
        .waddr   (s1_item_reg.waddr),
        .wdata   (s1_item_reg.wdata),
        .re      (adv),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (dens_qa),
        .rdata_b (dens_qb)
    );

    sti_ram #(
        .WIDTH (sti_pkg::DATA_W),
        .DEPTH (sti_pkg::STORE_DEPTH)
    ) u_cumulative_ram (
        .clk     (clk),
        .we      (cum_we),
        .waddr   (s1_item_reg.waddr),
        .wdata   (s1_item_reg.wdata),
        .re      (adv),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (cum_qa),
        .rdata_b (cum_qb)
    );

    assign a_sel     = (s2_flags_reg.kind == sti_pkg::KIND_DENSITY) ? dens_qa : cum_qa;
    assign b_sel     = (s2_flags_reg.kind == sti_pkg::KIND_DENSITY) ? dens_qb : cum_qb;
    assign delta     = $signed({1'b0, b_sel}) - $signed({1'b0, a_sel});
    assign prod_next = delta * $signed({1'b0, s2_frac_reg});

    // a + floor(((b - a) * f + half) / 2^24)
    assign rounded   = s3_prod_reg + 59'sd8388608;
    assign ival_wide = $signed({3'b000, s3_a_reg}) + rounded[58:24];
    assign ival      = ival_wide[31:0];
    assign integ     = s3_flags_reg.tail ? sti_pkg::HALF_Q24 : ival;
    assign sum_pos   = {1'b0, sti_pkg::HALF_Q24} + {1'b0, integ};

    always_comb
    begin
        if (s3_flags_reg.kind == sti_pkg::KIND_DENSITY)
        begin
            value_next = s3_flags_reg.tail ? '0 : ival;
        end
        else if (s3_flags_reg.zero)
        begin
            value_next = sti_pkg::HALF_Q24;
        end
        else if (!s3_flags_reg.neg)
        begin
            value_next = sum_pos[32] ? 32'hFFFF_FFFF : sum_pos[31:0];
        end
        else
        begin
            value_next = (integ >= sti_pkg::HALF_Q24) ? '0 : (sti_pkg::HALF_Q24 - integ);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= !empty;
            s2_valid_reg  <= s1_valid_reg && s1_query;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg   <= head;
            s1_pos_reg    <= 64'(head.diff) * 64'(head.inv);
            s2_flags_reg  <= '{kind: s1_item_reg.kind, neg: s1_item_reg.neg,
                               zero: s1_item_reg.zero, tail: s1_item_reg.tail};
            s2_frac_reg   <= frac;
            s3_flags_reg  <= s2_flags_reg;
            s3_a_reg      <= a_sel;
            s3_prod_reg   <= prod_next;
            out_value_reg <= value_next;
            out_tail_reg  <= s3_flags_reg.tail;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.value   = out_value_reg;
    assign result.in_tail = out_tail_reg;

    `STI_ASSERT_NOW(a_frac_at_most_one, clk, rst_n, s2_valid_reg,
        s2_frac_reg <= sti_pkg::ONE_Q24)
    `STI_ASSERT_NEXT(a_write_makes_no_result, clk, rst_n,
        adv && s1_valid_reg && !s1_query, !s2_valid_reg)
    `STI_ASSERT_NEXT(a_zero_cumulative_half, clk, rst_n,
        adv && s3_valid_reg && (s3_flags_reg.kind == sti_pkg::KIND_CUMULATIVE)
        && s3_flags_reg.zero, out_valid_reg && (out_value_reg == sti_pkg::HALF_Q24))
    `STI_ASSERT_NEXT(a_density_tail_zero, clk, rst_n,
        adv && s3_valid_reg && (s3_flags_reg.kind == sti_pkg::KIND_DENSITY)
        && s3_flags_reg.tail, (out_value_reg == '0) && out_tail_reg)

endmodule

@@ bench/sti_lookup_check.sv @@
`timescale 1ns / 1ps

module sti_lookup_check
    import sti_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    sti_in_if                    item_mon,
    sti_out_if                   result_mon,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   checked
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              in_tail;
    } lookup_t;

    logic [30:0]       bnd_one;
    logic [30:0]       bnd_two;
    logic [30:0]       bnd_three;
    logic [DATA_W-1:0] rstep_one;
    logic [DATA_W-1:0] rstep_two;
    logic [DATA_W-1:0] rstep_three;
    logic [DATA_W-1:0] density_tab    [STORE_DEPTH];
    logic [DATA_W-1:0] cumulative_tab [STORE_DEPTH];
    lookup_t           expected_lookups [$];
    lookup_t           want;
    int                err_cnt;
    int                chk_cnt;
    int unsigned       waddr;

    function automatic logic [DATA_W-1:0] lerp_entry(logic is_cum, int unsigned seg,
                                                     logic [31:0] diff, logic [31:0] inv);
        logic [63:0] pos;
        logic [63:0] lo_w;
        logic [63:0] hi_w;
        logic [63:0] acc;
        logic [23:0] idx;
        logic [24:0] frac;
        int unsigned addr;
        pos = {32'd0, diff} * {32'd0, inv};
        if (pos[63:40] >= 24'(SEG_POINTS))
        begin
            idx  = 24'(SEG_POINTS - 1);
            frac = ONE_Q24;
        end
        else
        begin
            idx  = pos[63:40];
            frac = {1'b0, pos[39:16]};
        end
        addr = seg * ROW_LEN + idx;
        lo_w = {32'd0, is_cum ? cumulative_tab[addr] : density_tab[addr]};
        hi_w = {32'd0, is_cum ? cumulative_tab[addr + 1] : density_tab[addr + 1]};
        acc  = lo_w * (64'(ONE_Q24) - 64'(frac)) + hi_w * 64'(frac) + 64'(HALF_Q24);
        return acc[55:24];
    endfunction

    function automatic lookup_t predict_lookup(logic is_cum, logic [31:0] energy);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] ival;
        logic [32:0] integ;
        logic [32:0] sum;
        lookup_t     res;
        neg         = energy[31];
        mag         = neg ? -energy : energy;
        ival        = '0;
        res.in_tail = 1'b0;
        if (mag < {1'b0, bnd_one})
            ival = lerp_entry(is_cum, 0, mag, rstep_one);
        else if (mag < {1'b0, bnd_two})
            ival = lerp_entry(is_cum, 1, mag - {1'b0, bnd_one}, rstep_two);
        else if (mag < {1'b0, bnd_three})
            ival = lerp_entry(is_cum, 2, mag - {1'b0, bnd_two}, rstep_three);
        else
            res.in_tail = 1'b1;

        if (!is_cum)
            res.value = res.in_tail ? '0 : ival;
        else if (energy == '0)
            res.value = HALF_Q24;
        else
        begin
            integ = res.in_tail ? {1'b0, HALF_Q24} : {1'b0, ival};
            if (!neg)
            begin
                sum       = {1'b0, HALF_Q24} + integ;
                res.value = sum[32] ? '1 : sum[31:0];
            end
            else
                res.value = (integ >= {1'b0, HALF_Q24}) ? '0 : HALF_Q24 - integ[31:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_one     = '0;
            bnd_two     = '0;
            bnd_three   = '0;
            rstep_one   = '0;
            rstep_two   = '0;
            rstep_three = '0;
            expected_lookups.delete();
            err_cnt     = 0;
            chk_cnt     = 0;
            mismatches <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BOUND_ONE:      bnd_one     = cfg_data[30:0];
                    CFG_BOUND_TWO:      bnd_two     = cfg_data[30:0];
                    CFG_BOUND_THREE:    bnd_three   = cfg_data[30:0];
                    CFG_INV_STEP_ONE:   rstep_one   = cfg_data;
                    CFG_INV_STEP_TWO:   rstep_two   = cfg_data;
                    CFG_INV_STEP_THREE: rstep_three = cfg_data;
                    default: ;
                endcase
            end

            if (item_mon.valid && item_mon.ready)
            begin
                if (item_mon.kind == KIND_WRITE)
                begin
                    if (item_mon.segment < SEG_COUNT && item_mon.entry_index <= SEG_POINTS)
                    begin
                        waddr = item_mon.segment * ROW_LEN + item_mon.entry_index;
                        if (item_mon.table_pick)
                            cumulative_tab[waddr] = item_mon.entry_value;
                        else
                            density_tab[waddr] = item_mon.entry_value;
                    end
                end
                else if (item_mon.kind == KIND_DENSITY || item_mon.kind == KIND_CUMULATIVE)
                    expected_lookups.push_back(
                        predict_lookup(item_mon.kind == KIND_CUMULATIVE, item_mon.energy));
            end

            if (result_mon.valid && result_mon.ready)
            begin
                if (expected_lookups.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result: value %h in_tail %b",
                                 result_mon.value, result_mon.in_tail);
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    chk_cnt++;
                    if (result_mon.value !== want.value || result_mon.in_tail !== want.in_tail)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"lookup mismatch: expected value %h in_tail %b,",
                                      " got value %h in_tail %b"},
                                     want.value, want.in_tail,
                                     result_mon.value, result_mon.in_tail);
                    end
                end
            end

            mismatches <= err_cnt;
            pending    <= expected_lookups.size();
            checked    <= chk_cnt;
        end
    end

endmodule

@@ bench/tb_segmented_table_interpolator.sv @@
`timescale 1ns / 1ps

module tb_segmented_table_interpolator;
    import sti_pkg::*;

    localparam logic [1:0]  KIND_UNUSED     = 2'd3;
    localparam int          ITEMS_PER_PHASE = 100;
    localparam int          PHASES          = 6;
    localparam int          SETTLE_CYCLES   = 20;
    localparam logic [31:0] BOUND_A_ONE     = 32'h0100_0000;
    localparam logic [31:0] BOUND_A_TWO     = 32'h0400_0000;
    localparam logic [31:0] BOUND_A_THREE   = 32'h1000_0000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    int                   mismatches;
    int                   pending;
    int                   checked;
    int                   src_idle;
    int                   sink_stall;
    int                   transactions_sent;
    int                   setting_count;
    logic [30:0]          cur_one;
    logic [30:0]          cur_two;
    logic [30:0]          cur_three;

    sti_in_if  item_ch ();
    sti_out_if result_ch ();

    segmented_table_interpolator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sti_lookup_check i_lookup_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_mon   (item_ch),
        .result_mon (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("run timed out");
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= sink_stall);

    function automatic logic [31:0] random_table_word();
        case ($urandom_range(3))
            0: return $urandom_range(32'h00FF_FFFF);
            1: return $urandom();
            2: return $urandom_range(32'h007F_FFFF);
            default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] span_pick(logic [31:0] lo, logic [31:0] hi);
        return (hi > lo) ? $urandom_range(hi - 1, lo) : lo;
    endfunction

    function automatic logic [31:0] random_energy();
        logic [31:0] mag;
        logic [31:0] near;
        case ($urandom_range(7))
            0: mag = $urandom_range(3);
            1: mag = span_pick(32'h0, {1'b0, cur_one});
            2: mag = span_pick({1'b0, cur_one}, {1'b0, cur_two});
            3: mag = span_pick({1'b0, cur_two}, {1'b0, cur_three});
            4:
            begin
                near = ($urandom_range(2) == 0) ? {1'b0, cur_one} :
                       ($urandom_range(1) ? {1'b0, cur_two} : {1'b0, cur_three});
                mag  = near + $urandom_range(2) - 1;
            end
            5: mag = span_pick({1'b0, cur_three}, 32'h8000_0000);
            6: return $urandom();
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h0;
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // about 256 grid intervals across the segment width, with some overshoot
    function automatic logic [31:0] step_for(logic [31:0] width);
        logic [63:0] q;
        q = (64'd1 << 48) / ((width == 0) ? 64'd1 : {32'd0, width});
        if (q > 64'hFFFF_FFFF)
            return '1;
        q = q + $urandom_range(q[31:0] >> 3);
        return (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
    endfunction

    task automatic set_reg(cfg_reg_t r, logic [31:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic load_config(logic [31:0] b1, logic [31:0] b2, logic [31:0] b3,
                               logic [31:0] s1, logic [31:0] s2, logic [31:0] s3);
        set_reg(CFG_BOUND_ONE, b1);
        set_reg(CFG_BOUND_TWO, b2);
        set_reg(CFG_BOUND_THREE, b3);
        set_reg(CFG_INV_STEP_ONE, s1);
        set_reg(CFG_INV_STEP_TWO, s2);
        set_reg(CFG_INV_STEP_THREE, s3);
        cfg_we <= 1'b0;
        cur_one   = b1[30:0];
        cur_two   = b2[30:0];
        cur_three = b3[30:0];
        setting_count++;
    endtask

    task automatic send_item(logic [1:0] kind, logic pick, logic [1:0] seg, logic [8:0] idx,
                             logic [31:0] val, logic [31:0] energy);
        while ($urandom_range(99) < src_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= kind;
        item_ch.table_pick  <= pick;
        item_ch.segment     <= seg;
        item_ch.entry_index <= idx;
        item_ch.entry_value <= val;
        item_ch.energy      <= energy;
        do
            @(posedge clk);
        while (!item_ch.ready);
        transactions_sent++;
    endtask

    task automatic send_write(logic pick, logic [1:0] seg, logic [8:0] idx, logic [31:0] val);
        send_item(KIND_WRITE, pick, seg, idx, val, $urandom());
    endtask

    task automatic send_query(logic [1:0] kind, logic [31:0] energy);
        send_item(kind, 1'($urandom_range(1)), 2'($urandom_range(3)), 9'($urandom_range(511)),
                  $urandom(), energy);
    endtask

    // hold the input idle until every lookup has returned, then let writes retire
    task automatic settle();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned roll;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;

        item_ch.valid       <= 1'b0;
        item_ch.kind        <= KIND_WRITE;
        item_ch.table_pick  <= 1'b0;
        item_ch.segment     <= '0;
        item_ch.entry_index <= '0;
        item_ch.entry_value <= '0;
        item_ch.energy      <= '0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_BOUND_ONE;
        cfg_data            <= '0;
        src_idle            = 0;
        sink_stall          = 0;
        transactions_sent   = 0;
        setting_count       = 0;
        cur_one             = '0;
        cur_two             = '0;
        cur_three           = '0;
        rst_n               <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_config(BOUND_A_ONE, BOUND_A_TWO, BOUND_A_THREE,
                    32'h0100_0000, 32'h0055_5555, 32'h0015_5555);

        // load every entry of both tables before any lookup
        for (int s = 0; s < SEG_COUNT; s++)
            for (int i = 0; i < ROW_LEN; i++)
            begin
                send_write(1'b0, 2'(s), 9'(i), random_table_word());
                send_write(1'b1, 2'(s), 9'(i), random_table_word());
            end

        send_query(KIND_DENSITY, 32'h0);
        send_query(KIND_CUMULATIVE, 32'h0);
        send_write(1'b0, 2'd3, 9'd5, 32'hDEAD_BEEF);
        send_write(1'b1, 2'd0, 9'd257, 32'hFFFF_FFFF);
        send_write(1'b0, 2'd2, 9'd511, 32'h0);
        send_item(KIND_UNUSED, 1'b1, 2'd3, 9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_query(KIND_CUMULATIVE, 32'h1);
        send_query(KIND_CUMULATIVE, 32'hFFFF_FFFF);
        send_query(KIND_DENSITY, BOUND_A_ONE - 1);
        send_query(KIND_CUMULATIVE, BOUND_A_ONE);
        send_query(KIND_CUMULATIVE, BOUND_A_TWO);
        send_query(KIND_CUMULATIVE, -(BOUND_A_TWO - 1));
        send_query(KIND_DENSITY, BOUND_A_THREE - 1);
        send_query(KIND_DENSITY, BOUND_A_THREE);
        send_query(KIND_CUMULATIVE, BOUND_A_THREE);
        send_query(KIND_CUMULATIVE, -BOUND_A_THREE);
        send_query(KIND_DENSITY, 32'h7FFF_FFFF);
        send_query(KIND_DENSITY, 32'h8000_0000);
        send_query(KIND_CUMULATIVE, 32'h8000_0000);
        send_write(1'b1, 2'd0, 9'd0, 32'hFFFF_FFFF);
        send_write(1'b1, 2'd0, 9'd1, 32'hFFFF_FFFF);
        send_query(KIND_CUMULATIVE, 32'h0000_0010);
        send_query(KIND_CUMULATIVE, 32'hFFFF_FFF0);
        send_write(1'b0, 2'd1, 9'd256, 32'hFFFF_FFFF);
        send_query(KIND_DENSITY, BOUND_A_TWO - 1);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    src_idle   = 0;
                    sink_stall = 0;
                end
                1, 5:
                begin
                    src_idle   = 45;
                    sink_stall = 0;
                end
                2:
                begin
                    src_idle   = 0;
                    sink_stall = 45;
                end
                default:
                begin
                    src_idle   = 22;
                    sink_stall = 22;
                end
            endcase

            case (p)
                1: load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3:
                begin
                    w2 = $urandom_range(32'h1000_0000, 1);
                    load_config(32'h0, w2, 32'h7FFF_FFFF, 32'h0, step_for(w2), 32'h0);
                end
                4: load_config($urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom(), $urandom());
                default:
                begin
                    w1 = $urandom_range(32'h0400_0000, 1);
                    w2 = w1 + $urandom_range(32'h0800_0000, 1);
                    w3 = w2 + $urandom_range(32'h2000_0000, 1);
                    load_config(w1, w2, w3, step_for(w1), step_for(w2 - w1), step_for(w3 - w2));
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                    settle();
                roll = $urandom_range(99);
                if (roll < 12)
                    send_write(1'($urandom_range(1)), 2'($urandom_range(3)),
                               9'($urandom_range(511)), random_table_word());
                else if (roll < 16)
                    send_item(KIND_UNUSED, 1'($urandom_range(1)), 2'($urandom_range(3)),
                              9'($urandom_range(511)), $urandom(), $urandom());
                else if (roll < 58)
                    send_query(KIND_DENSITY, random_energy());
                else
                    send_query(KIND_CUMULATIVE, random_energy());
            end
            settle();
        end

        $display({"Covered %0d transactions (table loads, lookups, unused kinds)",
                  " over %0d register settings"},
                 transactions_sent, setting_count);
        $display("Checked %0d lookups with no idling, sender gaps, receiver stalls and both",
                 checked);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sti_pkg.sv
rtl/core/sti_in_if.sv
rtl/core/sti_out_if.sv
rtl/core/sti_ram.sv
rtl/core/sti_queue.sv
rtl/core/sti_front.sv
rtl/core/sti_back.sv
rtl/core/segmented_table_interpolator.sv
bench/sti_lookup_check.sv
bench/tb_segmented_table_interpolator.sv
